@@ design/sbso_pkg.sv @@
// Shared widths, register map, sequencer and lane codes for the swept-box overlap core
package sbso_pkg;

	// coordinate and size formats (signed and unsigned Q.8)
	localparam int COORD_BITS = 24;
	localparam int SIZE_BITS  = COORD_BITS - 1;
	localparam int FRAC_BITS  = 8;

	// derived datapath widths
	localparam int POS_W  = COORD_BITS + 1;  // previous centre plus offset
	localparam int DIFF_W = COORD_BITS + 2;  // final minus start, step delta, start distance
	localparam int SAMP_W = COORD_BITS + 3;  // sample position
	localparam int SEP_W  = SAMP_W + 1;      // distance between two samples
	localparam int SUM_W  = SIZE_BITS + 1;   // sum of two full sizes

	// sub-step count
	localparam int MAX_STEPS  = 16;
	localparam int STEP_REG_W = 5;
	localparam int CNT_W      = $clog2(MAX_STEPS + 1);

	// shared divider: two quotient bits per cycle
	localparam int DIV_CYC   = (DIFF_W + 1) / 2;
	localparam int DIV_W     = 2 * DIV_CYC;
	localparam int DIV_CNT_W = $clog2(DIV_CYC);

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int IDX_W  = ADDR_W - 2;

	typedef enum logic [IDX_W-1:0] {
		REG_STEP_COUNT = 3'd0,
		REG_OFFSET_AX  = 3'd1,
		REG_OFFSET_AY  = 3'd2,
		REG_OFFSET_BX  = 3'd3,
		REG_OFFSET_BY  = 3'd4
	} reg_idx_t;

	// one divider lane per path axis
	typedef enum logic [1:0] {
		LANE_AX = 2'd0,
		LANE_AY = 2'd1,
		LANE_BX = 2'd2,
		LANE_BY = 2'd3
	} lane_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CHK  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_INIT = 6'b001000,
		ST_PAIR = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

endpackage

@@ design/substep_box_sweep_overlap_core.sv @@
// Substepped swept-box overlap core: config registers, shared divider and pair compare sequencer
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+----------------------------------------------
//  item      | item_valid / item_stall     | a_prev_*, a_final_*, a_size_*, b_* (12 fields)
//  result    | result_valid / result_stall | hit
//  config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  One item passes the coarse check, then the four step deltas are divided one after another
//  on the shared two-bit-per-cycle divider, then the single compare unit takes one sample
//  pair per cycle, up to N*N pairs for step count N, stopping at the first overlapping pair.
//  A coarse reject or N = 0 skips the division and the pairs and goes straight to the result.
//  item_stall stays high from the transfer until the result has been taken.
//  Reset clears the sequencer and loads the register reset values.
module substep_box_sweep_overlap_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// item channel
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic signed [sbso_pkg::COORD_BITS-1:0] a_prev_x,
	input  logic signed [sbso_pkg::COORD_BITS-1:0] a_prev_y,
	input  logic signed [sbso_pkg::COORD_BITS-1:0] a_final_x,
	input  logic signed [sbso_pkg::COORD_BITS-1:0] a_final_y,
	input  logic        [sbso_pkg::SIZE_BITS-1:0]  a_size_x,
	input  logic        [sbso_pkg::SIZE_BITS-1:0]  a_size_y,
	input  logic signed [sbso_pkg::COORD_BITS-1:0] b_prev_x,
	input  logic signed [sbso_pkg::COORD_BITS-1:0] b_prev_y,
	input  logic signed [sbso_pkg::COORD_BITS-1:0] b_final_x,
	input  logic signed [sbso_pkg::COORD_BITS-1:0] b_final_y,
	input  logic        [sbso_pkg::SIZE_BITS-1:0]  b_size_x,
	input  logic        [sbso_pkg::SIZE_BITS-1:0]  b_size_y,
	// result channel
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic                                   hit,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic        [sbso_pkg::ADDR_W-1:0]     paddr,
	input  logic        [sbso_pkg::DATA_W-1:0]     pwdata,
	output logic        [sbso_pkg::DATA_W-1:0]     prdata,
	output logic                                   pready
);
	import sbso_pkg::*;

	// configuration registers
	logic        [STEP_REG_W-1:0] step_count_q;
	logic signed [COORD_BITS-1:0] offset_ax_q;
	logic signed [COORD_BITS-1:0] offset_ay_q;
	logic signed [COORD_BITS-1:0] offset_bx_q;
	logic signed [COORD_BITS-1:0] offset_by_q;

	// sequencer
	state_t               state_q;
	lane_t                lane_q;
	lane_t                ld_lane;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     i_q;
	logic [CNT_W-1:0]     j_q;
	logic                 hit_q;

	// item registers
	logic signed [POS_W-1:0]      pax_q, pay_q, pbx_q, pby_q;
	logic signed [COORD_BITS-1:0] fax_q, fay_q, fbx_q, fby_q;
	logic        [SUM_W-1:0]      sum_x_q, sum_y_q;

	// divider and step deltas
	logic        [DIV_W-1:0]  q_q;
	logic        [CNT_W-1:0]  rem_q;
	logic                     neg_q;
	logic signed [DIFF_W-1:0] d_q [4];

	// sample positions
	logic signed [SAMP_W-1:0] ax_q, ay_q, bx_q, by_q;

	logic                     wr_en;
	logic [CNT_W-1:0]         n_eff;
	logic signed [DIFF_W-1:0] dist_x, dist_y;
	logic        [DIFF_W-1:0] dist_x_mag, dist_y_mag;
	logic        [DIFF_W-1:0] lim_x, lim_y;
	logic                     coarse_ok;
	logic signed [DIFF_W-1:0] div_op;
	logic        [DIFF_W-1:0] div_mag;
	logic        [CNT_W:0]    r1, r2;
	logic        [CNT_W-1:0]  r1_m, r2_m;
	logic                     b1, b2;
	logic        [DIV_W-1:0]  q_nxt;
	logic        [DIFF_W-1:0] quo;
	logic signed [DIFF_W-1:0] delta;
	logic signed [SAMP_W-1:0] b_first_x, b_first_y;
	logic signed [SEP_W-1:0]  sep_x, sep_y;
	logic        [SEP_W-1:0]  sep_x_mag, sep_y_mag;
	logic                     pair_hit;
	logic                     item_xfer;
	logic                     result_xfer;

	assign pready      = 1'b1;
	assign wr_en       = psel && penable && pwrite && pready;
	assign item_xfer   = item_valid && !item_stall;
	assign result_xfer = result_valid && !result_stall;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= STEP_REG_W'(1);
			offset_ax_q  <= '0;
			offset_ay_q  <= '0;
			offset_bx_q  <= '0;
			offset_by_q  <= '0;
		end else if (wr_en) begin
			unique case (paddr[ADDR_W-1:2])
				REG_STEP_COUNT: step_count_q <= pwdata[STEP_REG_W-1:0];
				REG_OFFSET_AX:  offset_ax_q  <= pwdata[COORD_BITS-1:0];
				REG_OFFSET_AY:  offset_ay_q  <= pwdata[COORD_BITS-1:0];
				REG_OFFSET_BX:  offset_bx_q  <= pwdata[COORD_BITS-1:0];
				REG_OFFSET_BY:  offset_by_q  <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (paddr[ADDR_W-1:2])
			REG_STEP_COUNT: prdata = {{(DATA_W-STEP_REG_W){1'b0}}, step_count_q};
			REG_OFFSET_AX:  prdata = {{(DATA_W-COORD_BITS){1'b0}}, offset_ax_q};
			REG_OFFSET_AY:  prdata = {{(DATA_W-COORD_BITS){1'b0}}, offset_ay_q};
			REG_OFFSET_BX:  prdata = {{(DATA_W-COORD_BITS){1'b0}}, offset_bx_q};
			REG_OFFSET_BY:  prdata = {{(DATA_W-COORD_BITS){1'b0}}, offset_by_q};
			default:        prdata = '0;
		endcase
	end

	// saturate the step count
	assign n_eff = (step_count_q > STEP_REG_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS)
		: CNT_W'(step_count_q);

	// coarse reject on whole-unit start distance
	always_comb begin
		dist_x     = DIFF_W'(pbx_q) - DIFF_W'(pax_q);
		dist_y     = DIFF_W'(pby_q) - DIFF_W'(pay_q);
		dist_x_mag = dist_x[DIFF_W-1] ? DIFF_W'(-dist_x) : DIFF_W'(dist_x);
		dist_y_mag = dist_y[DIFF_W-1] ? DIFF_W'(-dist_y) : DIFF_W'(dist_y);
		lim_x      = DIFF_W'(sum_x_q >> (FRAC_BITS + 1)) << 1;
		lim_y      = DIFF_W'(sum_y_q >> (FRAC_BITS + 1)) << 1;
		coarse_ok  = ((dist_x_mag >> FRAC_BITS) <= lim_x)
			&& ((dist_y_mag >> FRAC_BITS) <= lim_y);
	end

	// pick the path span for the lane about to enter the divider
	assign ld_lane = (state_q == ST_CHK) ? LANE_AX : lane_t'(lane_q + 2'd1);

	always_comb begin
		unique case (ld_lane)
			LANE_AX: div_op = DIFF_W'(fax_q) - DIFF_W'(pax_q);
			LANE_AY: div_op = DIFF_W'(fay_q) - DIFF_W'(pay_q);
			LANE_BX: div_op = DIFF_W'(fbx_q) - DIFF_W'(pbx_q);
			LANE_BY: div_op = DIFF_W'(fby_q) - DIFF_W'(pby_q);
			default: div_op = '0;
		endcase
		div_mag = div_op[DIFF_W-1] ? DIFF_W'(-div_op) : DIFF_W'(div_op);
	end

	// two restoring division steps per cycle
	always_comb begin
		r1    = {rem_q, q_q[DIV_W-1]};
		b1    = (r1 >= {1'b0, n_q});
		r1_m  = b1 ? CNT_W'(r1 - {1'b0, n_q}) : CNT_W'(r1);
		r2    = {r1_m, q_q[DIV_W-2]};
		b2    = (r2 >= {1'b0, n_q});
		r2_m  = b2 ? CNT_W'(r2 - {1'b0, n_q}) : CNT_W'(r2);
		q_nxt = {q_q[DIV_W-3:0], b1, b2};
		quo   = q_nxt[DIFF_W-1:0];
		delta = neg_q ? DIFF_W'(-quo) : DIFF_W'(quo);
	end

	// first B sample of each row
	assign b_first_x = SAMP_W'(pbx_q) + SAMP_W'(d_q[LANE_BX]);
	assign b_first_y = SAMP_W'(pby_q) + SAMP_W'(d_q[LANE_BY]);

	// shared compare unit: overlap of the current sample pair on both axes
	always_comb begin
		sep_x     = SEP_W'(ax_q) - SEP_W'(bx_q);
		sep_y     = SEP_W'(ay_q) - SEP_W'(by_q);
		sep_x_mag = sep_x[SEP_W-1] ? SEP_W'(-sep_x) : SEP_W'(sep_x);
		sep_y_mag = sep_y[SEP_W-1] ? SEP_W'(-sep_y) : SEP_W'(sep_y);
		pair_hit  = ({1'b0, sep_x_mag, 1'b0} <= (SEP_W + 2)'(sum_x_q))
			&& ({1'b0, sep_y_mag, 1'b0} <= (SEP_W + 2)'(sum_y_q));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (item_xfer) begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= (n_q != '0 && coarse_ok) ? ST_DIV : ST_DONE;
				end
				ST_DIV: if (div_cnt_q == DIV_CNT_W'(DIV_CYC - 1) && lane_q == LANE_BY) begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					state_q <= ST_PAIR;
				end
				ST_PAIR: if (pair_hit || (i_q == n_q && j_q == n_q)) begin
					state_q <= ST_DONE;
				end
				ST_DONE: if (result_xfer) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (item_xfer) begin
				// capture the item and add the offsets
				pax_q   <= POS_W'(a_prev_x) + POS_W'(offset_ax_q);
				pay_q   <= POS_W'(a_prev_y) + POS_W'(offset_ay_q);
				pbx_q   <= POS_W'(b_prev_x) + POS_W'(offset_bx_q);
				pby_q   <= POS_W'(b_prev_y) + POS_W'(offset_by_q);
				fax_q   <= a_final_x;
				fay_q   <= a_final_y;
				fbx_q   <= b_final_x;
				fby_q   <= b_final_y;
				sum_x_q <= SUM_W'(a_size_x) + SUM_W'(b_size_x);
				sum_y_q <= SUM_W'(a_size_y) + SUM_W'(b_size_y);
				n_q     <= n_eff;
				hit_q   <= 1'b0;
			end
			ST_CHK: begin
				// load the first lane into the divider
				lane_q    <= LANE_AX;
				div_cnt_q <= '0;
				q_q       <= DIV_W'(div_mag);
				rem_q     <= '0;
				neg_q     <= div_op[DIFF_W-1];
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_CYC - 1)) begin
					// store the step delta and load the next lane
					d_q[lane_q] <= delta;
					lane_q      <= ld_lane;
					div_cnt_q   <= '0;
					q_q         <= DIV_W'(div_mag);
					rem_q       <= '0;
					neg_q       <= div_op[DIFF_W-1];
				end else begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					q_q       <= q_nxt;
					rem_q     <= r2_m;
				end
			end
			ST_INIT: begin
				ax_q <= SAMP_W'(pax_q) + SAMP_W'(d_q[LANE_AX]);
				ay_q <= SAMP_W'(pay_q) + SAMP_W'(d_q[LANE_AY]);
				bx_q <= b_first_x;
				by_q <= b_first_y;
				i_q  <= CNT_W'(1);
				j_q  <= CNT_W'(1);
			end
			ST_PAIR: begin
				if (pair_hit) begin
					hit_q <= 1'b1;
				end else if (j_q == n_q) begin
					// advance to the next A sample, restart the B row
					i_q  <= i_q + CNT_W'(1);
					j_q  <= CNT_W'(1);
					ax_q <= ax_q + SAMP_W'(d_q[LANE_AX]);
					ay_q <= ay_q + SAMP_W'(d_q[LANE_AY]);
					bx_q <= b_first_x;
					by_q <= b_first_y;
				end else begin
					j_q  <= j_q + CNT_W'(1);
					bx_q <= bx_q + SAMP_W'(d_q[LANE_BX]);
					by_q <= by_q + SAMP_W'(d_q[LANE_BY]);
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_DONE);
	assign hit          = hit_q;

	// checks
	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("item taken while a result is pending");

	a_xfer_starts_check: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> state_q == ST_CHK)
		else $error("item transfer did not start the coarse check");

	a_pair_counters: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAIR |-> (i_q != '0 && i_q <= n_q && j_q != '0 && j_q <= n_q))
		else $error("sample counters out of range");

	a_hit_needs_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && hit) |-> n_q != '0)
		else $error("hit reported with no sub-steps");

	a_div_done_lane: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT |-> $past(lane_q) == LANE_BY)
		else $error("sample setup entered before the last delta");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the substepped swept-box overlap core
`timescale 1ns / 1ps

module testbench;
	import sbso_pkg::*;

	localparam longint C_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
	localparam longint C_MIN = -(longint'(1) <<< (COORD_BITS - 1));
	localparam longint S_MAX = (longint'(1) <<< SIZE_BITS) - 1;
	localparam int     STEP_CAP    = MAX_STEPS;
	localparam int     HOLD_CYCLES = 500;
	localparam int     QUIET_LIMIT = 4000;
	localparam int     END_WAIT    = 330;
	localparam int     N_PHASES    = 12;
	localparam logic [IDX_W-1:0] SPARE_REG = IDX_W'(5);

	typedef struct {
		logic signed [COORD_BITS-1:0] a_prev_x, a_prev_y, a_final_x, a_final_y;
		logic        [SIZE_BITS-1:0]  a_size_x, a_size_y;
		logic signed [COORD_BITS-1:0] b_prev_x, b_prev_y, b_final_x, b_final_y;
		logic        [SIZE_BITS-1:0]  b_size_x, b_size_y;
	} box_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic signed [COORD_BITS-1:0] a_prev_x = '0, a_prev_y = '0, a_final_x = '0, a_final_y = '0;
	logic        [SIZE_BITS-1:0]  a_size_x = '0, a_size_y = '0;
	logic signed [COORD_BITS-1:0] b_prev_x = '0, b_prev_y = '0, b_final_x = '0, b_final_y = '0;
	logic        [SIZE_BITS-1:0]  b_size_x = '0, b_size_y = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic hit;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// shadow copy of the register file
	logic        [STEP_REG_W-1:0] cfg_steps = STEP_REG_W'(1);
	logic signed [COORD_BITS-1:0] cfg_off_ax = '0, cfg_off_ay = '0;
	logic signed [COORD_BITS-1:0] cfg_off_bx = '0, cfg_off_by = '0;

	box_pair_t pending_pairs[$];
	logic      expected_hits[$];
	box_pair_t cur_pair;
	logic      item_taken = 1'b0;
	logic      want_hit;
	logic      calm = 1'b0;
	int        hold_asked = 0, hold_seen = 0, hold_left = 0;
	int        quiet_cycles = 0, fail_count = 0;
	int        pairs_sent = 0, results_checked = 0, hits_seen = 0, settings_written = 0;

	substep_box_sweep_overlap_core uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint gap(input longint a, input longint b);
		return (a > b) ? a - b : b - a;
	endfunction

	// whole-unit distance against twice the whole half-size sum
	function automatic logic coarse_pass(input longint pa, input longint pb,
			input longint sa, input longint sb);
		return (gap(pa, pb) >>> 8) <= ((sa + sb) >>> 9) * 2;
	endfunction

	// hit for one box pair under the current register settings
	function automatic logic predict_hit(input box_pair_t p);
		longint pax, pay, pbx, pby, fax, fay, fbx, fby;
		longint sax, say, sbx, sby, n, dax, day, dbx, dby, ax, ay, bx, by, i, j;
		logic found;
		pax = longint'(p.a_prev_x) + longint'(cfg_off_ax);
		pay = longint'(p.a_prev_y) + longint'(cfg_off_ay);
		pbx = longint'(p.b_prev_x) + longint'(cfg_off_bx);
		pby = longint'(p.b_prev_y) + longint'(cfg_off_by);
		fax = longint'(p.a_final_x);
		fay = longint'(p.a_final_y);
		fbx = longint'(p.b_final_x);
		fby = longint'(p.b_final_y);
		sax = longint'(p.a_size_x);
		say = longint'(p.a_size_y);
		sbx = longint'(p.b_size_x);
		sby = longint'(p.b_size_y);
		n = longint'(cfg_steps);
		found = 1'b0;
		if (n > STEP_CAP)
			n = STEP_CAP;
		if (n > 0 && coarse_pass(pax, pbx, sax, sbx) && coarse_pass(pay, pby, say, sby)) begin
			dax = (fax - pax) / n;
			day = (fay - pay) / n;
			dbx = (fbx - pbx) / n;
			dby = (fby - pby) / n;
			for (i = 1; i <= n && !found; i++) begin
				ax = pax + dax * i;
				ay = pay + day * i;
				for (j = 1; j <= n && !found; j++) begin
					bx = pbx + dbx * j;
					by = pby + dby * j;
					if (2 * gap(ax, bx) <= sax + sbx && 2 * gap(ay, by) <= say + sby)
						found = 1'b1;
				end
			end
		end
		return found;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] to_coord(input longint v);
		if (v > C_MAX)
			v = C_MAX;
		if (v < C_MIN)
			v = C_MIN;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic logic [SIZE_BITS-1:0] to_size(input longint v);
		if (v > S_MAX)
			v = S_MAX;
		if (v < 0)
			v = 0;
		return v[SIZE_BITS-1:0];
	endfunction

	function automatic longint rand_span(input int unsigned r);
		return longint'($urandom_range(2 * r)) - longint'(r);
	endfunction

	function automatic box_pair_t box_pair(input longint apx, apy, afx, afy, asx, asy,
			input longint bpx, bpy, bfx, bfy, bsx, bsy);
		box_pair_t p;
		p.a_prev_x = to_coord(apx);
		p.a_prev_y = to_coord(apy);
		p.a_final_x = to_coord(afx);
		p.a_final_y = to_coord(afy);
		p.a_size_x = to_size(asx);
		p.a_size_y = to_size(asy);
		p.b_prev_x = to_coord(bpx);
		p.b_prev_y = to_coord(bpy);
		p.b_final_x = to_coord(bfx);
		p.b_final_y = to_coord(bfy);
		p.b_size_x = to_size(bsx);
		p.b_size_y = to_size(bsy);
		return p;
	endfunction

	// two boxes moving near a common centre, offsets taken out of the start
	function automatic box_pair_t swept_pair();
		int unsigned reach;
		longint cx, cy;
		reach = 1 << $urandom_range(20, 2);
		cx = rand_span(1 << 22);
		cy = rand_span(1 << 22);
		return box_pair(cx - longint'(cfg_off_ax) + rand_span(reach),
			cy - longint'(cfg_off_ay) + rand_span(reach),
			cx + rand_span(4 * reach), cy + rand_span(4 * reach),
			$urandom_range(2 * reach), $urandom_range(2 * reach),
			cx - longint'(cfg_off_bx) + rand_span(reach),
			cy - longint'(cfg_off_by) + rand_span(reach),
			cx + rand_span(4 * reach), cy + rand_span(4 * reach),
			$urandom_range(2 * reach), $urandom_range(2 * reach));
	endfunction

	// raw bits in every field
	function automatic box_pair_t noise_pair();
		box_pair_t p;
		p.a_prev_x = COORD_BITS'($urandom);
		p.a_prev_y = COORD_BITS'($urandom);
		p.a_final_x = COORD_BITS'($urandom);
		p.a_final_y = COORD_BITS'($urandom);
		p.a_size_x = SIZE_BITS'($urandom);
		p.a_size_y = SIZE_BITS'($urandom);
		p.b_prev_x = COORD_BITS'($urandom);
		p.b_prev_y = COORD_BITS'($urandom);
		p.b_final_x = COORD_BITS'($urandom);
		p.b_final_y = COORD_BITS'($urandom);
		p.b_size_x = SIZE_BITS'($urandom);
		p.b_size_y = SIZE_BITS'($urandom);
		return p;
	endfunction

	task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_STEP_COUNT: cfg_steps = data[STEP_REG_W-1:0];
			REG_OFFSET_AX: cfg_off_ax = data[COORD_BITS-1:0];
			REG_OFFSET_AY: cfg_off_ay = data[COORD_BITS-1:0];
			REG_OFFSET_BX: cfg_off_bx = data[COORD_BITS-1:0];
			REG_OFFSET_BY: cfg_off_by = data[COORD_BITS-1:0];
			default: ;
		endcase
		settings_written++;
	endtask

	// hold until every queued pair is taken and every result has come back
	task automatic wait_drained();
		@(posedge clk);
		while (pending_pairs.size() != 0 || item_valid || expected_hits.size() != 0)
			@(posedge clk);
	endtask

	// item driver: present the next pair once the previous transfer is done
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (pending_pairs.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
				cur_pair = pending_pairs.pop_front();
				a_prev_x <= cur_pair.a_prev_x;
				a_prev_y <= cur_pair.a_prev_y;
				a_final_x <= cur_pair.a_final_x;
				a_final_y <= cur_pair.a_final_y;
				a_size_x <= cur_pair.a_size_x;
				a_size_y <= cur_pair.a_size_y;
				b_prev_x <= cur_pair.b_prev_x;
				b_prev_y <= cur_pair.b_prev_y;
				b_final_x <= cur_pair.b_final_x;
				b_final_y <= cur_pair.b_final_y;
				b_size_x <= cur_pair.b_size_x;
				b_size_y <= cur_pair.b_size_y;
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result stall: random, or a long hold-off when asked
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(99) < 24);
		end
	end

	// monitor: predict on item transfer, check on result transfer, watch for hangs
	always @(posedge clk) begin
		if (!arst_n) begin
			item_taken = 1'b0;
		end else begin
			item_taken = item_valid && !item_stall;
			if (item_taken) begin
				expected_hits.push_back(predict_hit(cur_pair));
				pairs_sent++;
			end
			if (result_valid && !result_stall) begin
				if (expected_hits.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: hit=%0b with nothing pending", hit);
				end else begin
					want_hit = expected_hits.pop_front();
					results_checked++;
					if (want_hit)
						hits_seen++;
					if (hit !== want_hit) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch on result %0d: hit expected %0b, got %0b",
								results_checked, want_hit, hit);
					end
				end
			end
			if (item_taken || (result_valid && !result_stall) ||
					(psel && penable && pwrite && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned phase_steps [N_PHASES] = '{16, 0, 2, 1, 3, 31, 4, 8, 5, 17, 2, 1};
		int unsigned phase_items [N_PHASES] = '{60, 100, 200, 180, 180, 50, 200, 120, 180, 50,
			170, 140};
		logic signed [COORD_BITS-1:0] oax, oay, obx, oby;
		int p, k;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed pairs under reset settings: one step, no offsets
		pending_pairs.push_back(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(box_pair(C_MAX, C_MAX, C_MAX, C_MAX, S_MAX, S_MAX,
			C_MAX, C_MAX, C_MAX, C_MAX, S_MAX, S_MAX));
		pending_pairs.push_back(box_pair(C_MIN, C_MIN, C_MIN, C_MIN, 0, 0,
			C_MIN, C_MIN, C_MIN, C_MIN, 0, 0));
		// opposite corners, largest boxes: coarse reject at its edge
		pending_pairs.push_back(box_pair(C_MIN, C_MIN, C_MIN, C_MIN, S_MAX, S_MAX,
			C_MAX, C_MAX, C_MAX, C_MAX, S_MAX, S_MAX));
		pending_pairs.push_back(box_pair(C_MAX, C_MIN, C_MIN, C_MAX, S_MAX, 0,
			C_MIN, C_MAX, C_MAX, C_MIN, 0, S_MAX));
		// edges just touching, then one fraction apart
		pending_pairs.push_back(box_pair(0, 0, 0, 0, 512, 512, 512, 0, 512, 0, 512, 512));
		pending_pairs.push_back(box_pair(0, 0, 0, 0, 512, 512, 513, 0, 513, 0, 512, 512));
		// coarse reject on one axis only
		pending_pairs.push_back(box_pair(0, 0, 0, 0, 256, 256, 0, 100000, 0, 0, 256, 256));
		pending_pairs.push_back(box_pair(0, 0, 0, 0, 256, 256, 100000, 0, 0, 0, 256, 256));
		// whole-unit distance equal to the coarse limit, then one past it
		pending_pairs.push_back(box_pair(0, 0, 0, 0, 256, 256, 767, 0, 767, 0, 256, 256));
		pending_pairs.push_back(box_pair(0, 0, 0, 0, 256, 256, 768, 0, 0, 0, 256, 256));
		// paths crossing in opposite directions
		pending_pairs.push_back(box_pair(-5000, 0, 5000, 0, 300, 300,
			5000, 0, -5000, 0, 300, 300));
		// odd size sums where the halved bit decides
		pending_pairs.push_back(box_pair(0, 0, 0, 0, 1, 1, 1, 0, 1, 0, 0, 0));
		pending_pairs.push_back(box_pair(-3, 7, -3, 7, 1, 3, -3, 8, -3, 8, 0, 0));
		wait_drained();

		for (p = 0; p < N_PHASES; p++) begin
			case (p % 4)
				0: begin
					oax = '0;
					oay = '0;
					obx = '0;
					oby = '0;
				end
				1: begin
					oax = C_MAX[COORD_BITS-1:0];
					oay = C_MIN[COORD_BITS-1:0];
					obx = C_MIN[COORD_BITS-1:0];
					oby = C_MAX[COORD_BITS-1:0];
				end
				2: begin
					oax = to_coord(rand_span(4096));
					oay = to_coord(rand_span(4096));
					obx = to_coord(rand_span(4096));
					oby = to_coord(rand_span(4096));
				end
				default: begin
					oax = COORD_BITS'($urandom);
					oay = COORD_BITS'($urandom);
					obx = COORD_BITS'($urandom);
					oby = COORD_BITS'($urandom);
				end
			endcase
			// upper data bits carry junk; only the register width must stick
			apb_write(REG_STEP_COUNT, {(DATA_W - STEP_REG_W)'($urandom),
				STEP_REG_W'(phase_steps[p])});
			apb_write(REG_OFFSET_AX, {8'($urandom), oax});
			apb_write(REG_OFFSET_AY, {8'($urandom), oay});
			apb_write(REG_OFFSET_BX, {8'($urandom), obx});
			apb_write(REG_OFFSET_BY, {8'($urandom), oby});
			if (p == 4)
				apb_write(SPARE_REG, $urandom);

			calm = (p == 3);
			if (p == 2)
				hold_asked++;
			for (k = 0; k < phase_items[p]; k++) begin
				if ($urandom_range(99) < 80)
					pending_pairs.push_back(swept_pair());
				else
					pending_pairs.push_back(noise_pair());
			end
			wait_drained();
		end

		calm = 1'b0;
		repeat (END_WAIT) @(posedge clk);
		if (expected_hits.size() != 0)
			fail_count++;
		$display("Sent %0d box pairs across %0d register writes (step counts 0 to 31,",
			pairs_sent, settings_written);
		$display("zero, extreme and random offsets); checked %0d results, %0d hits.",
			results_checked, hits_seen);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
design/sbso_pkg.sv
design/substep_box_sweep_overlap_core.sv
test/testbench.sv
